// ===== src/cbd_pkg.sv =====
// Shared types, constants and the hex digit decoder for the chunked body decoder.
package cbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [4:0] HEX_TEN      = 5'd10;
    localparam logic [4:0] HEX_NONE     = 5'd16;
    localparam int         DIGIT_BITS   = 4;

    typedef struct packed {
        logic digit_seen;
        logic skip_next;
        logic ending_after_skip;
        logic finished;
        logic overflow_flag;
    } flags_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       body_end;
        logic       leftover;
        logic       size_overflow;
    } result_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_NONE;
        if (c inside {[CHAR_0 : CHAR_9]}) begin
            v = {1'b0, 4'(c - CHAR_0)};
        end else if (c inside {[CHAR_UPPER_A : CHAR_UPPER_F]}) begin
            v = 5'(c - CHAR_UPPER_A) + HEX_TEN;
        end else if (c inside {[CHAR_LOWER_A : CHAR_LOWER_F]}) begin
            v = 5'(c - CHAR_LOWER_A) + HEX_TEN;
        end
        return v;
    endfunction

endpackage

// ===== src/cbd_step.sv =====
// Next-state and result logic for one byte of the chunked body decoder.
module cbd_step #(
    parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
    input  logic [7:0]           in_byte,
    input  logic                 new_body,
    input  logic [SIZE_BITS-1:0] size_accum,
    input  logic [SIZE_BITS-1:0] data_remaining,
    input  cbd_pkg::flags_t      flags,
    output logic [SIZE_BITS-1:0] size_accum_next,
    output logic [SIZE_BITS-1:0] data_remaining_next,
    output cbd_pkg::flags_t      flags_next,
    output cbd_pkg::result_t     result
);
    import cbd_pkg::*;

    logic [SIZE_BITS-1:0] size_cur;
    logic [SIZE_BITS-1:0] remain_cur;
    flags_t               flags_cur;
    logic [4:0]           digit;

    assign digit = hex_value(in_byte);

    always_comb begin
        size_cur   = new_body ? '0 : size_accum;
        remain_cur = new_body ? '0 : data_remaining;
        flags_cur  = new_body ? '0 : flags;

        size_accum_next     = size_cur;
        data_remaining_next = remain_cur;
        flags_next          = flags_cur;
        result              = '0;

        if (flags_cur.finished) begin
            result.leftover = 1'b1;
        end else if (flags_cur.skip_next) begin
            flags_next.skip_next = 1'b0;
            if (flags_cur.ending_after_skip) begin
                flags_next.ending_after_skip = 1'b0;
                flags_next.finished          = 1'b1;
                result.body_end              = 1'b1;
            end
        end else if (remain_cur != '0) begin
            result.payload_valid = 1'b1;
            result.payload_byte  = in_byte;
            data_remaining_next  = remain_cur - 1'b1;
        end else if (digit != HEX_NONE) begin
            if (size_cur[SIZE_BITS-1 -: DIGIT_BITS] != '0) begin
                flags_next.overflow_flag = 1'b1;
                flags_next.finished      = 1'b1;
            end else begin
                size_accum_next       = {size_cur[SIZE_BITS-DIGIT_BITS-1:0], digit[3:0]};
                flags_next.digit_seen = 1'b1;
            end
        end else if (flags_cur.digit_seen) begin
            flags_next.skip_next = 1'b1;
            if (size_cur == '0) begin
                flags_next.ending_after_skip = 1'b1;
            end else begin
                data_remaining_next   = size_cur;
                size_accum_next       = '0;
                flags_next.digit_seen = 1'b0;
            end
        end

        result.size_overflow = flags_next.overflow_flag;
    end

endmodule

// ===== src/chunked_body_decoder_top.sv =====
// Top level of the chunked transfer body decoder: state and result registers.
//
// Usage: feed the raw chunked body one byte per beat on the s_ channel
// (s_in_byte, s_new_body with s_valid/s_ready). Raise s_new_body with the
// first byte of a new body to clear all decoder state before that byte.
// Every input beat gives exactly one result beat on the m_ channel:
// m_payload_valid/m_payload_byte for chunk data, m_body_end on the byte that
// closes the zero-size line, m_leftover for bytes after the end, and the
// sticky m_size_overflow flag.
// The result beat is registered. Throughput: one byte per cycle while the
// m_ side accepts, set by the single result register that holds each beat.
// A stalled receiver holds the result register; s_ready stays high while the
// register is empty or being drained in the same cycle, so a stall of the
// m_ side holds the s_ side after one beat.
// Reset (aresetn low, synchronous) clears the decoder state and empties
// the result register.
module chunked_body_decoder_top #(
    parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_new_body,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_payload_valid,
    output logic [7:0] m_payload_byte,
    output logic       m_body_end,
    output logic       m_leftover,
    output logic       m_size_overflow
);
    import cbd_pkg::*;

    logic [SIZE_BITS-1:0] size_accum_reg;
    logic [SIZE_BITS-1:0] size_accum_next;
    logic [SIZE_BITS-1:0] data_remaining_reg;
    logic [SIZE_BITS-1:0] data_remaining_next;
    flags_t               flags_reg;
    flags_t               flags_next;
    result_t              result_next;
    result_t              result_reg;
    logic                 m_valid_reg;
    logic                 in_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    cbd_step #(
        .SIZE_BITS(SIZE_BITS)
    ) u_step (
        .in_byte             (s_in_byte),
        .new_body            (s_new_body),
        .size_accum          (size_accum_reg),
        .data_remaining      (data_remaining_reg),
        .flags               (flags_reg),
        .size_accum_next     (size_accum_next),
        .data_remaining_next (data_remaining_next),
        .flags_next          (flags_next),
        .result              (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_accum_reg     <= '0;
            data_remaining_reg <= '0;
            flags_reg          <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (in_fire) begin
                size_accum_reg     <= size_accum_next;
                data_remaining_reg <= data_remaining_next;
                flags_reg          <= flags_next;
                m_valid_reg        <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_valid = result_reg.payload_valid;
    assign m_payload_byte  = result_reg.payload_byte;
    assign m_body_end      = result_reg.body_end;
    assign m_leftover      = result_reg.leftover;
    assign m_size_overflow = result_reg.size_overflow;

`ifndef NO_ASSERTIONS
    a_leftover_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_leftover) |-> (!m_payload_valid && !m_body_end))
        else $error("leftover beat carries payload or end");

    a_finished_leftover: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && flags_reg.finished && !s_new_body) |=> (m_valid && m_leftover))
        else $error("byte after body end not flagged leftover");

    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && flags_reg.overflow_flag && !s_new_body) |=> m_size_overflow)
        else $error("overflow flag dropped without restart");

    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload_valid) |-> (m_payload_byte == 8'h00))
        else $error("payload byte nonzero outside chunk data");

    a_payload_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !s_new_body && data_remaining_reg != '0 && !flags_reg.finished
            && !flags_reg.skip_next) |=> (data_remaining_reg == $past(data_remaining_reg) - 1'b1))
        else $error("chunk byte count did not advance");
`endif

endmodule
